/* hdl/rlsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared types and constants of the rectangular-window segment clipper.
// ----------------------------------------------------------------------------
package rlsc_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CORNER_A_X = 2'd0,
      CSR_CORNER_A_Y = 2'd1,
      CSR_CORNER_B_X = 2'd2,
      CSR_CORNER_B_Y = 2'd3
   } csr_index_type;

   // Bit positions of the outside code
   localparam int CODE_LEFT  = 0;
   localparam int CODE_RIGHT = 1;
   localparam int CODE_ABOVE = 2;
   localparam int CODE_BELOW = 3;

   typedef enum logic [2:0] {
      MODE_PASS,
      MODE_REJECT,
      MODE_CLIP_END,
      MODE_CLIP_START,
      MODE_CLIP_BOTH
   } mode_type;

   typedef enum logic [1:0] {
      EDGE_LEFT,
      EDGE_RIGHT,
      EDGE_TOP,
      EDGE_BOTTOM
   } edge_type;

   typedef struct packed {
      logic       valid;
      mode_type   mode;
      logic [1:0] found;
      logic [1:0] neg;
      edge_type   edge_sel0;
      edge_type   edge_sel1;
   } ctl_type;

endpackage

/* hdl/rlsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_front
// Outside codes, edge products, exact range tests and edge selection in five
// register stages; hands each endpoint's crossing numerator and denominator
// to the divider.
// ----------------------------------------------------------------------------
module rlsc_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [COORD_BITS-1:0]   in_start_x,
   input  logic signed [COORD_BITS-1:0]   in_start_y,
   input  logic signed [COORD_BITS-1:0]   in_end_x,
   input  logic signed [COORD_BITS-1:0]   in_end_y,
   input  logic signed [COORD_BITS-1:0]   win_xl,
   input  logic signed [COORD_BITS-1:0]   win_xr,
   input  logic signed [COORD_BITS-1:0]   win_yb,
   input  logic signed [COORD_BITS-1:0]   win_yt,
   output rlsc_pkg::ctl_type              ctl,
   output logic signed [COORD_BITS-1:0]   pt_x [2],
   output logic signed [COORD_BITS-1:0]   pt_y [2],
   output logic        [2*COORD_BITS-1:0] mag [2],
   output logic        [COORD_BITS-1:0]   den [2]
);
   import rlsc_pkg::*;

   localparam int N = COORD_BITS;
   localparam int D = N + 1;
   localparam int P = 2 * N + 1;

   // Stage 0: input capture
   logic                v0_ff;
   logic signed [N-1:0] px0_ff [2];
   logic signed [N-1:0] py0_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      px0_ff[0] <= in_start_x;
      py0_ff[0] <= in_start_y;
      px0_ff[1] <= in_end_x;
      py0_ff[1] <= in_end_y;
   end

   // Stage 1: codes, deltas, distances to the edges
   logic [3:0]          code1_in [2];
   logic signed [D-1:0] dl1_in [2];
   logic signed [D-1:0] dr1_in [2];
   logic signed [D-1:0] db1_in [2];
   logic signed [D-1:0] dt1_in [2];
   logic signed [D-1:0] dx1_in;
   logic signed [D-1:0] dy1_in;
   mode_type            mode1_in;

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         code1_in[e] = '0;
         code1_in[e][CODE_LEFT]  = px0_ff[e] < win_xl;
         code1_in[e][CODE_RIGHT] = !(px0_ff[e] < win_xl) && (px0_ff[e] > win_xr);
         code1_in[e][CODE_ABOVE] = py0_ff[e] > win_yt;
         code1_in[e][CODE_BELOW] = !(py0_ff[e] > win_yt) && (py0_ff[e] < win_yb);
         dl1_in[e] = D'(win_xl) - D'(px0_ff[e]);
         dr1_in[e] = D'(win_xr) - D'(px0_ff[e]);
         db1_in[e] = D'(win_yb) - D'(py0_ff[e]);
         dt1_in[e] = D'(win_yt) - D'(py0_ff[e]);
      end
      dx1_in = D'(px0_ff[1]) - D'(px0_ff[0]);
      dy1_in = D'(py0_ff[1]) - D'(py0_ff[0]);
      if (code1_in[0] == 4'b0000 && code1_in[1] == 4'b0000) begin
         mode1_in = MODE_PASS;
      end else if ((code1_in[0] & code1_in[1]) != 4'b0000) begin
         mode1_in = MODE_REJECT;
      end else if (code1_in[0] == 4'b0000) begin
         mode1_in = MODE_CLIP_END;
      end else if (code1_in[1] == 4'b0000) begin
         mode1_in = MODE_CLIP_START;
      end else begin
         mode1_in = MODE_CLIP_BOTH;
      end
   end

   logic                v1_ff;
   mode_type            mode1_ff;
   logic [3:0]          code1_ff [2];
   logic signed [D-1:0] dl1_ff [2];
   logic signed [D-1:0] dr1_ff [2];
   logic signed [D-1:0] db1_ff [2];
   logic signed [D-1:0] dt1_ff [2];
   logic signed [D-1:0] dx1_ff;
   logic signed [D-1:0] dy1_ff;
   logic signed [N-1:0] px1_ff [2];
   logic signed [N-1:0] py1_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      mode1_ff <= mode1_in;
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      for (int e = 0; e < 2; e++) begin
         code1_ff[e] <= code1_in[e];
         dl1_ff[e]   <= dl1_in[e];
         dr1_ff[e]   <= dr1_in[e];
         db1_ff[e]   <= db1_in[e];
         dt1_ff[e]   <= dt1_in[e];
         px1_ff[e]   <= px0_ff[e];
         py1_ff[e]   <= py0_ff[e];
      end
   end

   // Stage 2: cross products of edge distances and deltas
   logic signed [P-1:0] al2_in [2];
   logic signed [P-1:0] ar2_in [2];
   logic signed [P-1:0] bb2_in [2];
   logic signed [P-1:0] bt2_in [2];
   logic [N-1:0]        adx2_in;
   logic [N-1:0]        ady2_in;

   always_comb begin
      logic signed [2*D-1:0] full_al;
      logic signed [2*D-1:0] full_ar;
      logic signed [2*D-1:0] full_bb;
      logic signed [2*D-1:0] full_bt;
      logic signed [D-1:0]   neg_dx;
      logic signed [D-1:0]   neg_dy;
      for (int e = 0; e < 2; e++) begin
         full_al = dl1_ff[e] * dy1_ff;
         full_ar = dr1_ff[e] * dy1_ff;
         full_bb = db1_ff[e] * dx1_ff;
         full_bt = dt1_ff[e] * dx1_ff;
         al2_in[e] = full_al[P-1:0];
         ar2_in[e] = full_ar[P-1:0];
         bb2_in[e] = full_bb[P-1:0];
         bt2_in[e] = full_bt[P-1:0];
      end
      neg_dx  = -dx1_ff;
      neg_dy  = -dy1_ff;
      adx2_in = dx1_ff[D-1] ? neg_dx[N-1:0] : dx1_ff[N-1:0];
      ady2_in = dy1_ff[D-1] ? neg_dy[N-1:0] : dy1_ff[N-1:0];
   end

   logic                v2_ff;
   mode_type            mode2_ff;
   logic [3:0]          code2_ff [2];
   logic                dxnz2_ff;
   logic                dxneg2_ff;
   logic                dynz2_ff;
   logic                dyneg2_ff;
   logic [N-1:0]        adx2_ff;
   logic [N-1:0]        ady2_ff;
   logic signed [P-1:0] al2_ff [2];
   logic signed [P-1:0] ar2_ff [2];
   logic signed [P-1:0] bb2_ff [2];
   logic signed [P-1:0] bt2_ff [2];
   logic signed [N-1:0] px2_ff [2];
   logic signed [N-1:0] py2_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mode2_ff  <= mode1_ff;
      dxnz2_ff  <= dx1_ff != '0;
      dxneg2_ff <= dx1_ff[D-1];
      dynz2_ff  <= dy1_ff != '0;
      dyneg2_ff <= dy1_ff[D-1];
      adx2_ff   <= adx2_in;
      ady2_ff   <= ady2_in;
      for (int e = 0; e < 2; e++) begin
         code2_ff[e] <= code1_ff[e];
         al2_ff[e]   <= al2_in[e];
         ar2_ff[e]   <= ar2_in[e];
         bb2_ff[e]   <= bb2_in[e];
         bt2_ff[e]   <= bt2_in[e];
         px2_ff[e]   <= px1_ff[e];
         py2_ff[e]   <= py1_ff[e];
      end
   end

   // Stage 3: exact range tests of each edge crossing, scaled by the delta
   logic [3:0] ok3_in [2];

   always_comb begin
      logic lb_le, lb_ge, lt_le, lt_ge;
      logic rb_le, rb_ge, rt_le, rt_ge;
      for (int e = 0; e < 2; e++) begin
         lb_le = al2_ff[e] <= bb2_ff[e];
         lb_ge = al2_ff[e] >= bb2_ff[e];
         lt_le = al2_ff[e] <= bt2_ff[e];
         lt_ge = al2_ff[e] >= bt2_ff[e];
         rb_le = ar2_ff[e] <= bb2_ff[e];
         rb_ge = ar2_ff[e] >= bb2_ff[e];
         rt_le = ar2_ff[e] <= bt2_ff[e];
         rt_ge = ar2_ff[e] >= bt2_ff[e];
         ok3_in[e] = '0;
         ok3_in[e][CODE_LEFT]  = dxneg2_ff ? (lb_le && lt_ge) : (lb_ge && lt_le);
         ok3_in[e][CODE_RIGHT] = dxneg2_ff ? (rb_le && rt_ge) : (rb_ge && rt_le);
         ok3_in[e][CODE_ABOVE] = dyneg2_ff ? (rt_le && lt_ge) : (lt_le && rt_ge);
         ok3_in[e][CODE_BELOW] = dyneg2_ff ? (rb_le && lb_ge) : (lb_le && rb_ge);
      end
   end

   logic                v3_ff;
   mode_type            mode3_ff;
   logic [3:0]          code3_ff [2];
   logic [3:0]          ok3_ff [2];
   logic                dxnz3_ff;
   logic                dxneg3_ff;
   logic                dynz3_ff;
   logic                dyneg3_ff;
   logic [N-1:0]        adx3_ff;
   logic [N-1:0]        ady3_ff;
   logic signed [P-1:0] al3_ff [2];
   logic signed [P-1:0] ar3_ff [2];
   logic signed [P-1:0] bb3_ff [2];
   logic signed [P-1:0] bt3_ff [2];
   logic signed [N-1:0] px3_ff [2];
   logic signed [N-1:0] py3_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      mode3_ff  <= mode2_ff;
      dxnz3_ff  <= dxnz2_ff;
      dxneg3_ff <= dxneg2_ff;
      dynz3_ff  <= dynz2_ff;
      dyneg3_ff <= dyneg2_ff;
      adx3_ff   <= adx2_ff;
      ady3_ff   <= ady2_ff;
      for (int e = 0; e < 2; e++) begin
         code3_ff[e] <= code2_ff[e];
         ok3_ff[e]   <= ok3_in[e];
         al3_ff[e]   <= al2_ff[e];
         ar3_ff[e]   <= ar2_ff[e];
         bb3_ff[e]   <= bb2_ff[e];
         bt3_ff[e]   <= bt2_ff[e];
         px3_ff[e]   <= px2_ff[e];
         py3_ff[e]   <= py2_ff[e];
      end
   end

   // Stage 4: take the first edge hit in left, right, top, bottom order
   edge_type            edge4_in [2];
   logic [1:0]          found4_in;
   logic [1:0]          neg4_in;
   logic [2*N-1:0]      mag4_in [2];
   logic [N-1:0]        den4_in [2];

   always_comb begin
      logic                hl, hr, ht, hb;
      logic signed [P-1:0] psel;
      logic signed [P-1:0] pneg;
      logic                dneg;
      for (int e = 0; e < 2; e++) begin
         hl = dxnz3_ff && code3_ff[e][CODE_LEFT]  && ok3_ff[e][CODE_LEFT];
         hr = dxnz3_ff && code3_ff[e][CODE_RIGHT] && ok3_ff[e][CODE_RIGHT];
         ht = dynz3_ff && code3_ff[e][CODE_ABOVE] && ok3_ff[e][CODE_ABOVE];
         hb = dynz3_ff && code3_ff[e][CODE_BELOW] && ok3_ff[e][CODE_BELOW];
         found4_in[e] = hl || hr || ht || hb;
         if (hl) begin
            edge4_in[e] = EDGE_LEFT;
            psel        = al3_ff[e];
            dneg        = dxneg3_ff;
            den4_in[e]  = adx3_ff;
         end else if (hr) begin
            edge4_in[e] = EDGE_RIGHT;
            psel        = ar3_ff[e];
            dneg        = dxneg3_ff;
            den4_in[e]  = adx3_ff;
         end else if (ht) begin
            edge4_in[e] = EDGE_TOP;
            psel        = bt3_ff[e];
            dneg        = dyneg3_ff;
            den4_in[e]  = ady3_ff;
         end else begin
            edge4_in[e] = EDGE_BOTTOM;
            psel        = bb3_ff[e];
            dneg        = dyneg3_ff;
            den4_in[e]  = ady3_ff;
         end
         pneg        = -psel;
         neg4_in[e]  = psel[P-1] ^ dneg;
         mag4_in[e]  = psel[P-1] ? pneg[2*N-1:0] : psel[2*N-1:0];
      end
   end

   ctl_type ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= v3_ff;
      end
      ctl_ff.mode      <= mode3_ff;
      ctl_ff.found     <= found4_in;
      ctl_ff.neg       <= neg4_in;
      ctl_ff.edge_sel0 <= edge4_in[0];
      ctl_ff.edge_sel1 <= edge4_in[1];
      for (int e = 0; e < 2; e++) begin
         pt_x[e] <= px3_ff[e];
         pt_y[e] <= py3_ff[e];
         mag[e]  <= mag4_in[e];
         den[e]  <= den4_in[e];
      end
   end

   assign ctl = ctl_ff;

endmodule

/* hdl/rlsc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_div
// Pipelined restoring divider: one quotient bit per stage. The quotient is
// known to fit COORD_BITS+1 bits, so only that many stages are built.
// ----------------------------------------------------------------------------
module rlsc_div #(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic [2*COORD_BITS-1:0] num,
   input  logic [COORD_BITS-1:0]   den,
   output logic [COORD_BITS:0]     quo,
   output logic                    frac
);
   localparam int N  = COORD_BITS;
   localparam int ST = N + 1;

   logic [N-1:0] rem_ff [ST];
   logic [N:0]   low_ff [ST];
   logic [N-1:0] den_ff [ST];
   logic [N:0]   quo_ff [ST];

   logic [N-1:0] rem_src [ST];
   logic [N:0]   low_src [ST];
   logic [N-1:0] den_src [ST];
   logic [N:0]   quo_src [ST];

   logic [N-1:0] rem_in [ST];
   logic [N:0]   quo_in [ST];

   always_comb begin
      rem_src[0] = {1'b0, num[2*N-1:N+1]};
      low_src[0] = num[N:0];
      den_src[0] = den;
      quo_src[0] = '0;
      for (int k = 1; k < ST; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         den_src[k] = den_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
   end

   always_comb begin
      logic [N:0] trial;
      logic [N:0] diff;
      for (int k = 0; k < ST; k++) begin
         trial     = {rem_src[k], low_src[k][N-k]};
         diff      = trial - {1'b0, den_src[k]};
         quo_in[k] = quo_src[k];
         if (trial >= {1'b0, den_src[k]}) begin
            rem_in[k]      = diff[N-1:0];
            quo_in[k][N-k] = 1'b1;
         end else begin
            rem_in[k] = trial[N-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ST; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_src[k];
         den_ff[k] <= den_src[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo  = quo_ff[ST-1];
   assign frac = rem_ff[ST-1] != '0;

endmodule

/* hdl/rlsc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_back
// Turns quotients into clipped coordinates (truncated toward zero), orders
// the endpoints and registers the response.
// ----------------------------------------------------------------------------
module rlsc_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rlsc_pkg::ctl_type            ctl,
   input  logic signed [COORD_BITS-1:0] pt_x [2],
   input  logic signed [COORD_BITS-1:0] pt_y [2],
   input  logic        [COORD_BITS:0]   quo [2],
   input  logic        [1:0]            frac,
   input  logic signed [COORD_BITS-1:0] win_xl,
   input  logic signed [COORD_BITS-1:0] win_xr,
   input  logic signed [COORD_BITS-1:0] win_yb,
   input  logic signed [COORD_BITS-1:0] win_yt,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   output logic signed [COORD_BITS-1:0] rsp_out_start_x,
   output logic signed [COORD_BITS-1:0] rsp_out_start_y,
   output logic signed [COORD_BITS-1:0] rsp_out_end_x,
   output logic signed [COORD_BITS-1:0] rsp_out_end_y
);
   import rlsc_pkg::*;

   localparam int N = COORD_BITS;
   localparam int W = N + 3;

   logic signed [N-1:0] cx [2];
   logic signed [N-1:0] cy [2];

   always_comb begin
      edge_type            esel;
      logic signed [N-1:0] base;
      logic signed [W-1:0] qext;
      logic signed [W-1:0] qadj;
      logic signed [W-1:0] fl;
      logic signed [W-1:0] res;
      for (int e = 0; e < 2; e++) begin
         esel = (e == 0) ? ctl.edge_sel0 : ctl.edge_sel1;
         base = (esel == EDGE_LEFT || esel == EDGE_RIGHT) ? pt_y[e] : pt_x[e];
         qext = W'(quo[e]);
         qadj = ctl.neg[e] ? -(qext + W'(frac[e])) : qext;
         fl   = W'(base) + qadj;
         // round the floor back up for negative values with a fraction
         if (frac[e] && fl[W-1]) begin
            res = fl + W'(1);
         end else begin
            res = fl;
         end
         case (esel)
            EDGE_LEFT: begin
               cx[e] = win_xl;
               cy[e] = res[N-1:0];
            end
            EDGE_RIGHT: begin
               cx[e] = win_xr;
               cy[e] = res[N-1:0];
            end
            EDGE_TOP: begin
               cx[e] = res[N-1:0];
               cy[e] = win_yt;
            end
            default: begin
               cx[e] = res[N-1:0];
               cy[e] = win_yb;
            end
         endcase
      end
   end

   logic                vis_in;
   logic signed [N-1:0] sx_in, sy_in, ex_in, ey_in;

   always_comb begin
      vis_in = 1'b0;
      sx_in  = pt_x[0];
      sy_in  = pt_y[0];
      ex_in  = pt_x[1];
      ey_in  = pt_y[1];
      case (ctl.mode)
         MODE_PASS: begin
            vis_in = 1'b1;
         end
         MODE_CLIP_END: begin
            vis_in = ctl.found[1];
            ex_in  = cx[1];
            ey_in  = cy[1];
         end
         MODE_CLIP_START: begin
            vis_in = ctl.found[0];
            sx_in  = pt_x[1];
            sy_in  = pt_y[1];
            ex_in  = cx[0];
            ey_in  = cy[0];
         end
         MODE_CLIP_BOTH: begin
            vis_in = ctl.found[0] && ctl.found[1];
            sx_in  = cx[0];
            sy_in  = cy[0];
            ex_in  = cx[1];
            ey_in  = cy[1];
         end
         default: begin
            vis_in = 1'b0;
         end
      endcase
      // drop coordinates of a rejected segment
      if (!vis_in) begin
         sx_in = '0;
         sy_in = '0;
         ex_in = '0;
         ey_in = '0;
      end
   end

   logic                valid_ff;
   logic                vis_ff;
   logic signed [N-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
      vis_ff <= vis_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_out_start_x = sx_ff;
   assign rsp_out_start_y = sy_ff;
   assign rsp_out_end_x   = ex_ff;
   assign rsp_out_end_y   = ey_ff;

endmodule

/* hdl/rect_line_segment_clipper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_line_segment_clipper
// Clips one segment per cycle against the window spanned by two corners.
//
//   channel  ports                      handshake
//   request  start, busy, req_*         taken when start=1 and busy=0
//   response rsp_valid, rsp_*           one-cycle strobe, no back-pressure
//   config   csr_wr_en, csr_index, csr_wr_data   written when csr_wr_en=1
//
// One segment can enter every cycle while busy is low. The divider retires one
// quotient bit per stage.
// Reset is synchronous; busy is high only while reset is held.
// The response strobe cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module rect_line_segment_clipper #(
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   output logic                                  rsp_valid,
   output logic                                  rsp_visible,
   output logic signed [COORD_BITS-1:0]          rsp_out_start_x,
   output logic signed [COORD_BITS-1:0]          rsp_out_start_y,
   output logic signed [COORD_BITS-1:0]          rsp_out_end_x,
   output logic signed [COORD_BITS-1:0]          rsp_out_end_y,
   input  logic                                  csr_wr_en,
   input  logic [rlsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wr_data
);
   import rlsc_pkg::*;

   localparam int N   = COORD_BITS;
   localparam int DLY = N + 1;

   typedef struct packed {
      logic signed [N-1:0] x0;
      logic signed [N-1:0] y0;
      logic signed [N-1:0] x1;
      logic signed [N-1:0] y1;
   } pts_type;

   // Configuration registers and the sorted window bounds
   logic signed [N-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [N-1:0] xl_ff, xr_ff, yb_ff, yt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= '0;
         by_ff <= '0;
         xl_ff <= '0;
         xr_ff <= '0;
         yb_ff <= '0;
         yt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CORNER_A_X: ax_ff <= csr_wr_data;
               CSR_CORNER_A_Y: ay_ff <= csr_wr_data;
               CSR_CORNER_B_X: bx_ff <= csr_wr_data;
               CSR_CORNER_B_Y: by_ff <= csr_wr_data;
               default: ;
            endcase
         end
         xl_ff <= (ax_ff < bx_ff) ? ax_ff : bx_ff;
         xr_ff <= (ax_ff < bx_ff) ? bx_ff : ax_ff;
         yb_ff <= (ay_ff < by_ff) ? ay_ff : by_ff;
         yt_ff <= (ay_ff < by_ff) ? by_ff : ay_ff;
      end
   end

   assign busy = reset;

   ctl_type               f_ctl;
   logic signed [N-1:0]   f_px [2];
   logic signed [N-1:0]   f_py [2];
   logic        [2*N-1:0] f_mag [2];
   logic        [N-1:0]   f_den [2];

   rlsc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_start_x (req_start_x),
      .in_start_y (req_start_y),
      .in_end_x   (req_end_x),
      .in_end_y   (req_end_y),
      .win_xl     (xl_ff),
      .win_xr     (xr_ff),
      .win_yb     (yb_ff),
      .win_yt     (yt_ff),
      .ctl        (f_ctl),
      .pt_x       (f_px),
      .pt_y       (f_py),
      .mag        (f_mag),
      .den        (f_den)
   );

   logic [N:0] d_quo [2];
   logic [1:0] d_frac;

   rlsc_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div0 (
      .clock (clock),
      .num   (f_mag[0]),
      .den   (f_den[0]),
      .quo   (d_quo[0]),
      .frac  (d_frac[0])
   );

   rlsc_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div1 (
      .clock (clock),
      .num   (f_mag[1]),
      .den   (f_den[1]),
      .quo   (d_quo[1]),
      .frac  (d_frac[1])
   );

   // Hold control and endpoints alongside the divider stages
   ctl_type ctl_dly_ff [DLY];
   pts_type pts_dly_ff [DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) begin
            ctl_dly_ff[k] <= '0;
         end
      end else begin
         ctl_dly_ff[0] <= f_ctl;
         for (int k = 1; k < DLY; k++) begin
            ctl_dly_ff[k] <= ctl_dly_ff[k-1];
         end
      end
      pts_dly_ff[0].x0 <= f_px[0];
      pts_dly_ff[0].y0 <= f_py[0];
      pts_dly_ff[0].x1 <= f_px[1];
      pts_dly_ff[0].y1 <= f_py[1];
      for (int k = 1; k < DLY; k++) begin
         pts_dly_ff[k] <= pts_dly_ff[k-1];
      end
   end

   logic signed [N-1:0] b_px [2];
   logic signed [N-1:0] b_py [2];

   assign b_px[0] = pts_dly_ff[DLY-1].x0;
   assign b_py[0] = pts_dly_ff[DLY-1].y0;
   assign b_px[1] = pts_dly_ff[DLY-1].x1;
   assign b_py[1] = pts_dly_ff[DLY-1].y1;

   rlsc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl_dly_ff[DLY-1]),
      .pt_x            (b_px),
      .pt_y            (b_py),
      .quo             (d_quo),
      .frac            (d_frac),
      .win_xl          (xl_ff),
      .win_xr          (xr_ff),
      .win_yb          (yb_ff),
      .win_yt          (yt_ff),
      .rsp_valid       (rsp_valid),
      .rsp_visible     (rsp_visible),
      .rsp_out_start_x (rsp_out_start_x),
      .rsp_out_start_y (rsp_out_start_y),
      .rsp_out_end_x   (rsp_out_end_x),
      .rsp_out_end_y   (rsp_out_end_y)
   );

endmodule
